// ===== src/sahc_pkg.sv =====
// Shared types and constants for the surface area heuristic split cost evaluator.
// Used by sahc_ctrl, sahc_datapath and sah_split_cost_evaluator; depends on nothing.
package sahc_pkg;

    localparam int COORD_W       = 24;
    localparam int CNT_W         = 13;
    localparam int MAX_TRIANGLES = 4096;
    localparam int CAP_INT       = (MAX_TRIANGLES < 8191) ? MAX_TRIANGLES : 8191;
    localparam int EXT_W         = COORD_W;
    localparam int MUL_A_W       = EXT_W + 1;
    localparam int MUL_B_W       = EXT_W;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int AREA_W        = 2 * EXT_W + 2;
    localparam int AREA_LO_W     = AREA_W / 2;
    localparam int ACC_W         = 65;
    localparam int COST_W        = 64;
    localparam int HI_KEEP_W     = ACC_W - AREA_LO_W - 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = COORD_W;

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_POSITION = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XY,
        ST_YZ,
        ST_ZX,
        ST_AREA,
        ST_LO,
        ST_HI,
        ST_TERM,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_XY,
        MUL_YZ,
        MUL_ZX,
        MUL_CLO,
        MUL_CHI
    } mul_sel_t;

    typedef struct packed {
        logic     accum_en;
        logic     side;
        mul_sel_t mul_sel;
        logic     mul_en;
        logic     area_clr;
        logic     area_add;
        logic     acc_clr;
        logic     acc_add_lo;
        logic     acc_add_hi;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== src/sahc_ctrl.sv =====
// Sequencer for the split cost evaluator: accepts triangles and steps the cost
// calculation through the shared multiplier. Depends on sahc_pkg.
module sahc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last_triangle,
    output logic            in_ready,
    input  sahc_pkg::status_t status,
    output sahc_pkg::cmd_t    cmd
);
    import sahc_pkg::*;

    state_t state_reg, state_next;
    logic   side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.side       = side_reg;
        cmd.mul_sel    = MUL_XY;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accum_en = 1'b1;
                    if (last_triangle)
                    begin
                        cmd.acc_clr = 1'b1;
                        side_next   = 1'b0;
                        state_next  = ST_XY;
                    end
                end
            end
            ST_XY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_XY;
                cmd.area_clr = 1'b1;
                state_next   = ST_YZ;
            end
            ST_YZ:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_YZ;
                cmd.area_add = 1'b1;
                state_next   = ST_ZX;
            end
            ST_ZX:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_ZX;
                cmd.area_add = 1'b1;
                state_next   = ST_AREA;
            end
            ST_AREA:
            begin
                cmd.area_add = 1'b1;
                state_next   = ST_LO;
            end
            ST_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CLO;
                state_next  = ST_HI;
            end
            ST_HI:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_CHI;
                cmd.acc_add_lo = 1'b1;
                state_next     = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.acc_add_hi = 1'b1;
                if (side_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    side_next  = 1'b1;
                    state_next = ST_XY;
                end
            end
            ST_FINISH:
            begin
                // The result register must be free before the accumulators are cleared.
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_stay_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !(in_valid && last_triangle)) |=> (state_reg == ST_IDLE))
        else $error("sequencer left idle without a last triangle");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while the cost is being computed");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("finish step did not return to idle");

    a_second_side: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TERM && !side_reg) |=> (state_reg == ST_XY && side_reg))
        else $error("right side was not evaluated after the left side");

endmodule

// ===== src/sahc_datapath.sv =====
// Datapath of the split cost evaluator: side counts, bounding boxes, the shared
// multiplier, the cost accumulator and the result register. Depends on sahc_pkg.
module sahc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sahc_pkg::cmd_t                        cmd,
    output sahc_pkg::status_t                     status,
    input  logic                                  cfg_valid,
    input  logic [sahc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sahc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   centre_on_axis,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sahc_pkg::COST_W-1:0]           split_cost,
    output logic                                  no_split,
    output logic [sahc_pkg::CNT_W-1:0]            left_total,
    output logic [sahc_pkg::CNT_W-1:0]            right_total
);
    import sahc_pkg::*;

    // The axis select is held for software; centre_on_axis arrives already projected.
    logic [1:0]                split_axis_reg;
    logic signed [COORD_W-1:0] split_position_reg;

    logic [CNT_W-1:0]          lcnt_reg, rcnt_reg;
    logic signed [COORD_W-1:0] lmin_reg [3];
    logic signed [COORD_W-1:0] lmax_reg [3];
    logic signed [COORD_W-1:0] rmin_reg [3];
    logic signed [COORD_W-1:0] rmax_reg [3];

    logic signed [COORD_W-1:0] vtx [3][3];
    logic signed [COORD_W-1:0] tri_min [3];
    logic signed [COORD_W-1:0] tri_max [3];
    logic signed [COORD_W-1:0] lmin_next [3];
    logic signed [COORD_W-1:0] lmax_next [3];
    logic signed [COORD_W-1:0] rmin_next [3];
    logic signed [COORD_W-1:0] rmax_next [3];
    logic [CNT_W-1:0]          lcnt_next, rcnt_next;
    logic                      go_left;

    logic signed [COORD_W:0]   diff [3];
    logic [EXT_W-1:0]          ext [3];
    logic [CNT_W-1:0]          side_cnt;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         prod_reg;
    logic [AREA_W-1:0]         area_reg, area_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;

    logic                      out_valid_reg;
    logic [COST_W-1:0]         split_cost_reg;
    logic                      no_split_reg;
    logic [CNT_W-1:0]          left_total_reg, right_total_reg;
    logic [COST_W-1:0]         cost_value;
    logic                      flag_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_axis_reg     <= '0;
            split_position_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPLIT_AXIS:     split_axis_reg     <= cfg_data[1:0];
                REG_SPLIT_POSITION: split_position_reg <= cfg_data;
                default:            split_axis_reg     <= split_axis_reg;
            endcase
        end
    end

    // Triangle classification and box growth.
    always_comb
    begin
        vtx[0][0] = vertex0_x;
        vtx[0][1] = vertex0_y;
        vtx[0][2] = vertex0_z;
        vtx[1][0] = vertex1_x;
        vtx[1][1] = vertex1_y;
        vtx[1][2] = vertex1_z;
        vtx[2][0] = vertex2_x;
        vtx[2][1] = vertex2_y;
        vtx[2][2] = vertex2_z;
        go_left = (centre_on_axis < split_position_reg);
        for (int k = 0; k < 3; k++)
        begin
            tri_min[k] = vtx[0][k];
            tri_max[k] = vtx[0][k];
            for (int t = 1; t < 3; t++)
            begin
                if (vtx[t][k] < tri_min[k])
                    tri_min[k] = vtx[t][k];
                if (vtx[t][k] > tri_max[k])
                    tri_max[k] = vtx[t][k];
            end
            lmin_next[k] = lmin_reg[k];
            lmax_next[k] = lmax_reg[k];
            rmin_next[k] = rmin_reg[k];
            rmax_next[k] = rmax_reg[k];
            if (cmd.finish)
            begin
                lmin_next[k] = COORD_MAX;
                lmax_next[k] = COORD_MIN;
                rmin_next[k] = COORD_MAX;
                rmax_next[k] = COORD_MIN;
            end
            else if (cmd.accum_en && go_left)
            begin
                if (tri_min[k] < lmin_reg[k])
                    lmin_next[k] = tri_min[k];
                if (tri_max[k] > lmax_reg[k])
                    lmax_next[k] = tri_max[k];
            end
            else if (cmd.accum_en)
            begin
                if (tri_min[k] < rmin_reg[k])
                    rmin_next[k] = tri_min[k];
                if (tri_max[k] > rmax_reg[k])
                    rmax_next[k] = tri_max[k];
            end
        end
        lcnt_next = lcnt_reg;
        rcnt_next = rcnt_reg;
        if (cmd.finish)
        begin
            lcnt_next = '0;
            rcnt_next = '0;
        end
        else if (cmd.accum_en && go_left)
        begin
            if (lcnt_reg < COUNT_CAP)
                lcnt_next = lcnt_reg + 1'b1;
        end
        else if (cmd.accum_en)
        begin
            if (rcnt_reg < COUNT_CAP)
                rcnt_next = rcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcnt_reg <= '0;
            rcnt_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                lmin_reg[k] <= COORD_MAX;
                lmax_reg[k] <= COORD_MIN;
                rmin_reg[k] <= COORD_MAX;
                rmax_reg[k] <= COORD_MIN;
            end
        end
        else
        begin
            lcnt_reg <= lcnt_next;
            rcnt_reg <= rcnt_next;
            for (int k = 0; k < 3; k++)
            begin
                lmin_reg[k] <= lmin_next[k];
                lmax_reg[k] <= lmax_next[k];
                rmin_reg[k] <= rmin_next[k];
                rmax_reg[k] <= rmax_next[k];
            end
        end
    end

    // Extents of the side under evaluation. An empty side gives garbage here,
    // which the final selection overrides.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.side)
                diff[k] = {rmax_reg[k][COORD_W-1], rmax_reg[k]}
                        - {rmin_reg[k][COORD_W-1], rmin_reg[k]};
            else
                diff[k] = {lmax_reg[k][COORD_W-1], lmax_reg[k]}
                        - {lmin_reg[k][COORD_W-1], lmin_reg[k]};
            ext[k] = diff[k][EXT_W-1:0];
        end
        side_cnt = cmd.side ? rcnt_reg : lcnt_reg;
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_XY:
            begin
                mul_a = {1'b0, ext[0]};
                mul_b = ext[1];
            end
            MUL_YZ:
            begin
                mul_a = {1'b0, ext[1]};
                mul_b = ext[2];
            end
            MUL_ZX:
            begin
                mul_a = {1'b0, ext[2]};
                mul_b = ext[0];
            end
            MUL_CLO:
            begin
                mul_a = MUL_A_W'(area_reg[AREA_LO_W-1:0]);
                mul_b = MUL_B_W'(side_cnt);
            end
            MUL_CHI:
            begin
                mul_a = MUL_A_W'(area_reg[AREA_W-1:AREA_LO_W]);
                mul_b = MUL_B_W'(side_cnt);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The area register holds the half area; the doubling is a one-bit shift of
    // the low term and is folded into the offset of the high term.
    always_comb
    begin
        area_next = area_reg;
        if (cmd.area_clr)
            area_next = '0;
        else if (cmd.area_add)
            area_next = area_reg + AREA_W'(prod_reg);
        acc_next = acc_reg;
        if (cmd.acc_clr)
            acc_next = '0;
        else if (cmd.acc_add_lo)
            acc_next = acc_reg + {{(ACC_W-PROD_W-1){1'b0}}, prod_reg, 1'b0};
        else if (cmd.acc_add_hi)
            acc_next = acc_reg + {prod_reg[HI_KEEP_W-1:0], {(AREA_LO_W+1){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        area_reg <= area_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        cost_value = '1;
        flag_value = 1'b1;
        if (lcnt_reg != '0 && rcnt_reg != '0)
        begin
            if (acc_reg[ACC_W-1])
            begin
                flag_value = 1'b0;
            end
            else if (acc_reg[COST_W-1:0] != '0)
            begin
                cost_value = acc_reg[COST_W-1:0];
                flag_value = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            split_cost_reg  <= cost_value;
            no_split_reg    <= flag_value;
            left_total_reg  <= lcnt_reg;
            right_total_reg <= rcnt_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign split_cost      = split_cost_reg;
    assign no_split        = no_split_reg;
    assign left_total      = left_total_reg;
    assign right_total     = right_total_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= COUNT_CAP) && (rcnt_reg <= COUNT_CAP))
        else $error("side count passed its cap");

    a_clear_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (lcnt_reg == '0 && rcnt_reg == '0 && out_valid_reg))
        else $error("accumulators not cleared when the result was loaded");

    a_flag_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && no_split_reg) |-> (split_cost_reg == '1))
        else $error("no-split result without the all-ones sentinel");

endmodule

// ===== src/sah_split_cost_evaluator.sv =====
// Top level of the surface area heuristic split cost evaluator.
// Instantiates sahc_ctrl and sahc_datapath; depends on sahc_pkg.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    three vertices, centre, last flag
//   out      output     out_valid / out_ready  split cost, no-split flag, counts
//   cfg      input      cfg_valid / cfg_ready  register index and data
//
// A triangle that is not last is taken and the next can follow at once.
// The last triangle starts a cost sequence (7 steps per side through one
// shared 25x24 multiplier, plus a load step), during which in_ready is low.
// The result waits in an output register; a stalled result holds the load step only.
// Reset clears counts and boxes at once; cfg_ready is always high.
module sah_split_cost_evaluator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex0_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex1_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_x,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_y,
    input  logic signed [sahc_pkg::COORD_W-1:0]   vertex2_z,
    input  logic signed [sahc_pkg::COORD_W-1:0]   centre_on_axis,
    input  logic                                  last_triangle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sahc_pkg::COST_W-1:0]           split_cost,
    output logic                                  no_split,
    output logic [sahc_pkg::CNT_W-1:0]            left_total,
    output logic [sahc_pkg::CNT_W-1:0]            right_total,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sahc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sahc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sahc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sahc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last_triangle (last_triangle),
        .in_ready      (in_ready),
        .status        (status),
        .cmd           (cmd)
    );

    sahc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vertex0_x      (vertex0_x),
        .vertex0_y      (vertex0_y),
        .vertex0_z      (vertex0_z),
        .vertex1_x      (vertex1_x),
        .vertex1_y      (vertex1_y),
        .vertex1_z      (vertex1_z),
        .vertex2_x      (vertex2_x),
        .vertex2_y      (vertex2_y),
        .vertex2_z      (vertex2_z),
        .centre_on_axis (centre_on_axis),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .split_cost     (split_cost),
        .no_split       (no_split),
        .left_total     (left_total),
        .right_total    (right_total)
    );

endmodule
